[hdl/alid_pkg.sv]
// Shared types and constants for the array list insert/delete unit.
`default_nettype none

package alid_pkg;

   localparam int IDX_W  = 6;
   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_PUSH   = 3'd1,
      CMD_FETCH  = 3'd2,
      CMD_UPDATE = 3'd3,
      CMD_DELETE = 3'd4,
      CMD_POP    = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_STEP,
      S_INS_MOVE,
      S_DEL_STEP,
      S_DEL_MOVE,
      S_FETCH_RD,
      S_FETCH_OUT,
      S_STATUS
   } state_type;

endpackage

`default_nettype wire

[hdl/array_list_insert_delete_unit.sv]
// Array list unit: ordered list in RAM with insert/push/fetch/update/delete/pop.
// Push, update, pop and rejected commands pass through S_STATUS to the result; insert and delete
//   move one RAM word per step/move state pair (read in the step state, write in the move state).
// Fetch emits the elements in order, each through a RAM read state and then an output register load.
// Throughput: one command at a time; req_ready is high only while the sequencer is idle.
// Reset (synchronous, active high) empties the list; the RAM itself is not cleared.
`default_nettype none

module array_list_insert_delete_unit
   import alid_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // command channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic [IDX_W-1:0]         req_index,
   input  wire logic signed [DATA_W-1:0] req_value,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_data,
   output logic [IDX_W-1:0]              rsp_position,
   output logic [STAT_W-1:0]             rsp_status,
   output logic                          rsp_last
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // sequencer state
   state_type              state_ff,  state_in;
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic [ADDR_W-1:0]      ptr_ff,    ptr_in;
   logic [ADDR_W-1:0]      idx_ff,    idx_in;
   logic [WORD_BITS-1:0]   value_ff,  value_in;
   status_type             status_ff, status_in;

   // output register
   logic                   rsp_valid_ff,    rsp_valid_in;
   logic [DATA_W-1:0]      rsp_data_ff,     rsp_data_in;
   logic [IDX_W-1:0]       rsp_position_ff, rsp_position_in;
   status_type             rsp_status_ff,   rsp_status_in;
   logic                   rsp_last_ff,     rsp_last_in;

   // RAM port controls
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;

   logic                   req_xfer;
   logic                   out_free;
   logic                   list_full;
   logic                   list_empty;
   logic                   idx_bad;
   logic [CMP_W-1:0]       idx_wide;
   logic [CMP_W-1:0]       ptr_wide;
   logic [CNT_W-1:0]       ptr_next_cnt;
   logic [WORD_BITS-1:0]   req_word;

   alid_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_xfer   = req_valid && req_ready;
   // the output register can take a new result when empty or draining this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign list_full  = (count_ff == CAP_CNT);
   assign list_empty = (count_ff == '0);
   assign idx_wide   = CMP_W'(req_index);
   assign idx_bad    = (idx_wide >= CMP_W'(count_ff));
   assign ptr_wide   = CMP_W'(ptr_ff);
   assign ptr_next_cnt = CNT_W'(ptr_ff) + CNT_W'(1);
   // store only the low bits of the incoming word, zero-extended
   assign req_word   = WORD_BITS'($unsigned(req_value));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff          <= ptr_in;
      idx_ff          <= idx_in;
      value_ff        <= value_in;
      status_ff       <= status_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_position_ff <= rsp_position_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      idx_in          = idx_ff;
      value_in        = value_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      rsp_position_in = rsp_position_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = ptr_ff;
      ram_wr_data     = ram_rd_data;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               idx_in   = idx_wide[ADDR_W-1:0];
               value_in = req_word;
               unique case (req_command)
                  CMD_INSERT: begin
                     if (list_full) begin
                        status_in = ST_FULL;
                        state_in  = S_STATUS;
                     end else if (idx_bad) begin
                        status_in = ST_RANGE;
                        state_in  = S_STATUS;
                     end else begin
                        // open a gap by walking down from the current end
                        ptr_in   = count_ff[ADDR_W-1:0];
                        state_in = S_INS_STEP;
                     end
                  end
                  CMD_PUSH: begin
                     if (list_full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[ADDR_W-1:0];
                        ram_wr_data = req_word;
                        count_in    = count_ff + CNT_W'(1);
                        status_in   = ST_OK;
                     end
                     state_in = S_STATUS;
                  end
                  CMD_FETCH: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_STATUS;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_FETCH_RD;
                     end
                  end
                  CMD_UPDATE: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                     end else if (idx_bad) begin
                        status_in = ST_RANGE;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = idx_wide[ADDR_W-1:0];
                        ram_wr_data = req_word;
                        status_in   = ST_OK;
                     end
                     state_in = S_STATUS;
                  end
                  CMD_DELETE: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_STATUS;
                     end else if (idx_bad) begin
                        status_in = ST_RANGE;
                        state_in  = S_STATUS;
                     end else begin
                        ptr_in   = idx_wide[ADDR_W-1:0];
                        state_in = S_DEL_STEP;
                     end
                  end
                  CMD_POP: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in  = count_ff - CNT_W'(1);
                        status_in = ST_OK;
                     end
                     state_in = S_STATUS;
                  end
                  default: begin
                     // unused codes: drop the command, no result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_INS_STEP: begin
            if (ptr_ff == idx_ff) begin
               // gap reached: drop the new word in
               ram_wr_en   = 1'b1;
               ram_wr_addr = ptr_ff;
               ram_wr_data = value_ff;
               count_in    = count_ff + CNT_W'(1);
               status_in   = ST_OK;
               state_in    = S_STATUS;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff - ADDR_W'(1);
               state_in    = S_INS_MOVE;
            end
         end

         S_INS_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = ram_rd_data;
            ptr_in      = ptr_ff - ADDR_W'(1);
            state_in    = S_INS_STEP;
         end

         S_DEL_STEP: begin
            if (ptr_next_cnt == count_ff) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_STATUS;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff + ADDR_W'(1);
               state_in    = S_DEL_MOVE;
            end
         end

         S_DEL_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = ram_rd_data;
            ptr_in      = ptr_ff + ADDR_W'(1);
            state_in    = S_DEL_STEP;
         end

         S_FETCH_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_ff;
            state_in    = S_FETCH_OUT;
         end

         S_FETCH_OUT: begin
            // hold the read word until the output register frees up
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = DATA_W'(ram_rd_data);
               rsp_position_in = ptr_wide[IDX_W-1:0];
               rsp_status_in   = ST_OK;
               rsp_last_in     = (ptr_next_cnt == count_ff);
               if (ptr_next_cnt == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + ADDR_W'(1);
                  state_in = S_FETCH_RD;
               end
            end
         end

         S_STATUS: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = '0;
               rsp_position_in = '0;
               rsp_status_in   = status_ff;
               rsp_last_in     = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef ASSERT_OFF
   // the count never exceeds the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("element count above capacity");

   // a successful push grows the list by exactly one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_command == CMD_PUSH && !list_full)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not advance the count");

   // a fetch element that is not the last keeps the sequencer busy
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |-> !req_ready)
      else $error("unit idle while a fetch is still in progress");

   // while the unit is idle and taking commands, no RAM read is issued
   a_idle_no_move: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ram_rd_en)
      else $error("RAM read issued while idle");
`endif

endmodule

`default_nettype wire

[hdl/alid_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module alid_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
